@@ src/size_class_slot_allocator_assert.svh @@
// Assertion macros shared by the slot allocator RTL.
`ifndef SIZE_CLASS_SLOT_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_SLOT_ALLOCATOR_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define SCSA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SCSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/scsa_pkg.sv @@
// Types, codes and class ranges for the size class slot allocator.
package scsa_pkg;

  localparam int MAP_DEPTH      = 32;
  localparam int SLOT_W         = 5;
  localparam int COUNT_W        = 6;

  localparam int BASIC_SLOTS    = 16;
  localparam int DATAGRAM_SLOTS = 8;
  localparam int STREAM_SLOTS   = 8;

  typedef logic [MAP_DEPTH-1:0] slot_map_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CLASS_BASIC    = 2'd0,
    CLASS_DATAGRAM = 2'd1,
    CLASS_STREAM   = 2'd2,
    CLASS_INVALID  = 2'd3
  } size_class_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NO_SLOT     = 2'd1,
    STATUS_FREE_RELEASE = 2'd2
  } status_t;

  function automatic int clip_to_map(input int v);
    return (v > MAP_DEPTH) ? MAP_DEPTH : v;
  endfunction

  // Bit i set when first <= i < last, range clipped to the map.
  function automatic slot_map_t range_mask(input int first, input int last);
    slot_map_t m;
    int        lo;
    int        hi;
    lo = clip_to_map(first);
    hi = clip_to_map(last);
    for (int i = 0; i < MAP_DEPTH; i++) begin
      m[i] = (i >= lo) && (i < hi);
    end
    return m;
  endfunction

  localparam slot_map_t BASIC_MASK    = range_mask(0, BASIC_SLOTS);
  localparam slot_map_t DATAGRAM_MASK = range_mask(BASIC_SLOTS, BASIC_SLOTS + DATAGRAM_SLOTS);
  localparam slot_map_t STREAM_MASK   = range_mask(BASIC_SLOTS + DATAGRAM_SLOTS,
                                                   BASIC_SLOTS + DATAGRAM_SLOTS + STREAM_SLOTS);
  localparam slot_map_t POOL_MASK     = BASIC_MASK | DATAGRAM_MASK | STREAM_MASK;

endpackage

@@ src/scsa_ifs.sv @@
// Request and result channel interfaces of the slot allocator.
interface scsa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [1:0]                     size_class;
  logic [scsa_pkg::SLOT_W-1:0]    slot;

  modport source (output valid, output operation, output size_class, output slot,
                  input ready);
  modport sink   (input valid, input operation, input size_class, input slot,
                  output ready);
endinterface

interface scsa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [scsa_pkg::SLOT_W-1:0]    granted_slot;
  logic [scsa_pkg::COUNT_W-1:0]   live_count;
  logic [scsa_pkg::COUNT_W-1:0]   peak_count;

  modport source (output valid, output status, output granted_slot, output live_count,
                  output peak_count, input ready);
  modport sink   (input valid, input status, input granted_slot, input live_count,
                  input peak_count, output ready);
endinterface

@@ src/size_class_slot_allocator.sv @@
// Slot allocator: one request per cycle when not stalled (request register, result
// register). Each request word is an allocate (grants the lowest free slot of the named
// class: basic, datagram or stream) or a release (frees the named slot). Every request
// returns exactly one result word with status, granted slot, live count and peak count.
// The throughput is one word per cycle, set by the find-first-free encoder over the
// 32-slot in-use map; a stalled result register holds the request register, and the
// request register holds the input. Allocation in an unknown or full class and release
// of a free slot change no state and report a failure status.
`include "size_class_slot_allocator_assert.svh"

module size_class_slot_allocator (
  input  logic              clk,
  input  logic              rst_n,
  scsa_req_if.sink          in_ch,
  scsa_rsp_if.source        out_ch
);

  // request register
  logic                            req_vld_r;
  logic                            req_op_r;
  logic [1:0]                      req_class_r;
  logic [scsa_pkg::SLOT_W-1:0]     req_slot_r;

  // allocator state
  scsa_pkg::slot_map_t             in_use_r;
  scsa_pkg::slot_map_t             in_use_nxt;
  logic [scsa_pkg::COUNT_W-1:0]    live_r;
  logic [scsa_pkg::COUNT_W-1:0]    live_nxt;
  logic [scsa_pkg::COUNT_W-1:0]    peak_r;
  logic [scsa_pkg::COUNT_W-1:0]    peak_nxt;

  // result register
  logic                            out_vld_r;
  scsa_pkg::status_t               out_status_r;
  scsa_pkg::status_t               out_status_nxt;
  logic [scsa_pkg::SLOT_W-1:0]     out_grant_r;
  logic [scsa_pkg::SLOT_W-1:0]     out_grant_nxt;
  // counts in the result word are the state left by that word's request
  logic [scsa_pkg::COUNT_W-1:0]    out_live_r;
  logic [scsa_pkg::COUNT_W-1:0]    out_peak_r;

  logic                            out_free;
  logic                            advance;
  logic                            take_in;

  scsa_pkg::slot_map_t             class_mask;
  scsa_pkg::slot_map_t             free_map;
  logic                            found;
  logic [scsa_pkg::SLOT_W-1:0]     grant_idx;
  logic                            alloc_ok;

  assign out_free = !out_vld_r || out_ch.ready;
  assign advance  = req_vld_r && out_free;
  assign take_in  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !req_vld_r || out_free;

  always_comb begin
    unique case (req_class_r)
      scsa_pkg::CLASS_BASIC:    class_mask = scsa_pkg::BASIC_MASK;
      scsa_pkg::CLASS_DATAGRAM: class_mask = scsa_pkg::DATAGRAM_MASK;
      scsa_pkg::CLASS_STREAM:   class_mask = scsa_pkg::STREAM_MASK;
      default:                  class_mask = '0;
    endcase
  end

  assign free_map = ~in_use_r & class_mask;
  assign found    = |free_map;

  // lowest free slot: scan from the top so the last hit wins
  always_comb begin
    grant_idx = '0;
    for (int i = scsa_pkg::MAP_DEPTH - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        grant_idx = scsa_pkg::SLOT_W'(i);
      end
    end
  end

  assign alloc_ok = (req_op_r == scsa_pkg::OP_ALLOC) && found;

  always_comb begin
    in_use_nxt     = in_use_r;
    live_nxt       = live_r;
    peak_nxt       = peak_r;
    out_status_nxt = scsa_pkg::STATUS_OK;
    out_grant_nxt  = '0;
    if (req_op_r == scsa_pkg::OP_ALLOC) begin
      if (found) begin
        in_use_nxt[grant_idx] = 1'b1;
        live_nxt              = live_r + scsa_pkg::COUNT_W'(1);
        if (live_nxt > peak_r) begin
          peak_nxt = live_nxt;
        end
        out_grant_nxt = grant_idx;
      end else begin
        out_status_nxt = scsa_pkg::STATUS_NO_SLOT;
      end
    end else begin
      if (in_use_r[req_slot_r]) begin
        in_use_nxt[req_slot_r] = 1'b0;
        if (live_r != '0) begin
          live_nxt = live_r - scsa_pkg::COUNT_W'(1);
        end
      end else begin
        out_status_nxt = scsa_pkg::STATUS_FREE_RELEASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      in_use_r  <= '0;
      live_r    <= '0;
      peak_r    <= '0;
    end else begin
      if (in_ch.ready) begin
        req_vld_r <= in_ch.valid;
      end
      if (out_free) begin
        out_vld_r <= req_vld_r;
      end
      if (advance) begin
        in_use_r <= in_use_nxt;
        live_r   <= live_nxt;
        peak_r   <= peak_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      req_op_r    <= in_ch.operation;
      req_class_r <= in_ch.size_class;
      req_slot_r  <= in_ch.slot;
    end
    if (advance) begin
      out_status_r <= out_status_nxt;
      out_grant_r  <= out_grant_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_live_r <= live_nxt;
      out_peak_r <= peak_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.granted_slot = out_grant_r;
  assign out_ch.live_count   = out_live_r;
  assign out_ch.peak_count   = out_peak_r;

  `SCSA_ASSERT_ALWAYS(a_live_matches_map,
                      live_r == scsa_pkg::COUNT_W'($countones(in_use_r)),
                      "live count differs from in-use map")
  `SCSA_ASSERT_ALWAYS(a_peak_covers_live, peak_r >= live_r,
                      "peak count below live count")
  `SCSA_ASSERT_ALWAYS(a_map_inside_pool, (in_use_r & ~scsa_pkg::POOL_MASK) == '0,
                      "slot outside every class marked in use")
  `SCSA_ASSERT_SAME(a_grant_in_class, advance && alloc_ok,
                    class_mask[grant_idx] && !in_use_r[grant_idx],
                    "grant outside class or already in use")
  `SCSA_ASSERT_NEXT(a_grant_marked, advance && alloc_ok, in_use_r[$past(grant_idx)],
                    "granted slot not marked in use")

endmodule

@@ tb/sv/tb_size_class_slot_allocator.sv @@
// Self-checking testbench for the size class slot allocator.
`timescale 1ns / 1ps

module tb_size_class_slot_allocator;
  import scsa_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_OFF_LEN  = 60;
  localparam int PHASE_WORDS   = 400;
  localparam int DIRECTED_ROWS = 21;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    granted_slot;
    logic [COUNT_W-1:0]   live_count;
    logic [COUNT_W-1:0]   peak_count;
  } slot_result_t;

  typedef struct packed {
    op_t                  op;
    size_class_t          size_class;
    logic [SLOT_W-1:0]    slot;
    logic                 typed;
    slot_result_t         want;
  } request_row_t;

  // Typed rows carry the result read straight off the spec; the rest use the predictor.
  localparam request_row_t REQUEST_TABLE [DIRECTED_ROWS] = '{
    '{OP_RELEASE, CLASS_BASIC,    5'd0,  1'b1, '{STATUS_FREE_RELEASE, 5'd0,  6'd0, 6'd0}},
    '{OP_ALLOC,   CLASS_INVALID,  5'd31, 1'b1, '{STATUS_NO_SLOT,      5'd0,  6'd0, 6'd0}},
    '{OP_ALLOC,   CLASS_BASIC,    5'd31, 1'b1, '{STATUS_OK,           5'd0,  6'd1, 6'd1}},
    '{OP_ALLOC,   CLASS_DATAGRAM, 5'd0,  1'b1, '{STATUS_OK,           5'd16, 6'd2, 6'd2}},
    '{OP_ALLOC,   CLASS_STREAM,   5'd0,  1'b1, '{STATUS_OK,           5'd24, 6'd3, 6'd3}},
    '{OP_RELEASE, CLASS_INVALID,  5'd31, 1'b1, '{STATUS_FREE_RELEASE, 5'd0,  6'd3, 6'd3}},
    '{OP_RELEASE, CLASS_BASIC,    5'd0,  1'b1, '{STATUS_OK,           5'd0,  6'd2, 6'd3}},
    '{OP_ALLOC,   CLASS_BASIC,    5'd0,  1'b1, '{STATUS_OK,           5'd0,  6'd3, 6'd3}},
    '{OP_RELEASE, CLASS_STREAM,   5'd16, 1'b1, '{STATUS_OK,           5'd0,  6'd2, 6'd3}},
    '{OP_ALLOC,   CLASS_STREAM,   5'd7,  1'b0, '0},
    '{OP_ALLOC,   CLASS_STREAM,   5'd8,  1'b0, '0},
    '{OP_ALLOC,   CLASS_STREAM,   5'd21, 1'b0, '0},
    '{OP_ALLOC,   CLASS_STREAM,   5'd10, 1'b0, '0},
    '{OP_ALLOC,   CLASS_STREAM,   5'd5,  1'b0, '0},
    '{OP_ALLOC,   CLASS_STREAM,   5'd2,  1'b0, '0},
    '{OP_ALLOC,   CLASS_STREAM,   5'd1,  1'b0, '0},
    '{OP_ALLOC,   CLASS_STREAM,   5'd0,  1'b1, '{STATUS_NO_SLOT,      5'd0,  6'd9, 6'd9}},
    '{OP_RELEASE, CLASS_DATAGRAM, 5'd31, 1'b1, '{STATUS_OK,           5'd0,  6'd8, 6'd9}},
    '{OP_RELEASE, CLASS_DATAGRAM, 5'd31, 1'b1, '{STATUS_FREE_RELEASE, 5'd0,  6'd8, 6'd9}},
    '{OP_ALLOC,   CLASS_STREAM,   5'd0,  1'b0, '0},
    '{OP_RELEASE, CLASS_BASIC,    5'd20, 1'b1, '{STATUS_FREE_RELEASE, 5'd0,  6'd9, 6'd9}}
  };

  logic clk;
  logic rst_n;

  scsa_req_if req_ch ();
  scsa_rsp_if rsp_ch ();

  size_class_slot_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  // Predictor state
  slot_map_t          pool_map;
  logic [COUNT_W-1:0] live_slots;
  logic [COUNT_W-1:0] peak_slots;

  slot_result_t pending_results[$];
  logic         pend_typed;
  slot_result_t pend_typed_res;

  int req_gap_pct;
  int rsp_stall_pct;
  int hold_off_requests;
  int hold_off_seen;
  int hold_off_left;
  int cycle_count;
  int mismatch_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n              = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.operation   = 1'b0;
    req_ch.size_class  = 2'd0;
    req_ch.slot        = '0;
    rsp_ch.ready       = 1'b1;
    pend_typed         = 1'b0;
    pend_typed_res     = '0;
    req_gap_pct        = 0;
    rsp_stall_pct      = 0;
    hold_off_requests  = 0;
    hold_off_seen      = 0;
    hold_off_left      = 0;
    cycle_count        = 0;
    mismatch_count     = 0;
    pool_map           = '0;
    live_slots         = '0;
    peak_slots         = '0;
  end

  function automatic slot_result_t predict_slot_request(op_t op, size_class_t cls,
                                                        logic [SLOT_W-1:0] slot);
    slot_result_t res;
    int           lo;
    int           hi;
    int           pick;
    res  = '{STATUS_OK, '0, '0, '0};
    pick = -1;
    if (op == OP_ALLOC) begin
      case (cls)
        CLASS_BASIC: begin
          lo = 0;
          hi = BASIC_SLOTS;
        end
        CLASS_DATAGRAM: begin
          lo = BASIC_SLOTS;
          hi = BASIC_SLOTS + DATAGRAM_SLOTS;
        end
        CLASS_STREAM: begin
          lo = BASIC_SLOTS + DATAGRAM_SLOTS;
          hi = BASIC_SLOTS + DATAGRAM_SLOTS + STREAM_SLOTS;
        end
        default: begin
          lo = 0;
          hi = 0;
        end
      endcase
      if (lo > MAP_DEPTH) lo = MAP_DEPTH;
      if (hi > MAP_DEPTH) hi = MAP_DEPTH;
      for (int i = hi - 1; i >= lo; i--) begin
        if (!pool_map[i]) pick = i;
      end
      if (pick >= 0) begin
        pool_map[pick] = 1'b1;
        live_slots = live_slots + 1'b1;
        if (live_slots > peak_slots) peak_slots = live_slots;
        res.granted_slot = SLOT_W'(pick);
      end else begin
        res.status = STATUS_NO_SLOT;
      end
    end else begin
      if (pool_map[slot]) begin
        pool_map[slot] = 1'b0;
        if (live_slots != 0) live_slots = live_slots - 1'b1;
      end else begin
        res.status = STATUS_FREE_RELEASE;
      end
    end
    res.live_count = live_slots;
    res.peak_count = peak_slots;
    return res;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Request side first so a result in the same cycle as its request would still find its expectation.
  always @(posedge clk) begin
    slot_result_t want;
    slot_result_t got;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        want = predict_slot_request(op_t'(req_ch.operation),
                                    size_class_t'(req_ch.size_class), req_ch.slot);
        if (pend_typed) want = pend_typed_res;
        pending_results.push_back(want);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{status_t'(rsp_ch.status), rsp_ch.granted_slot, rsp_ch.live_count,
                rsp_ch.peak_count};
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: status %0d slot %0d live %0d peak %0d",
                 got.status, got.granted_slot, got.live_count, got.peak_count);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("granted_slot", want.granted_slot, got.granted_slot);
          check_field("live_count", want.live_count, got.live_count);
          check_field("peak_count", want.peak_count, got.peak_count);
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off_requests != hold_off_seen) begin
      hold_off_seen = hold_off_requests;
      hold_off_left = HOLD_OFF_LEN;
    end
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic send_request(op_t op, size_class_t cls, logic [SLOT_W-1:0] slot,
                              logic typed, slot_result_t want);
    while ($urandom_range(99) < req_gap_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.size_class <= cls;
    req_ch.slot       <= slot;
    pend_typed        <= typed;
    pend_typed_res    <= want;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Alloc-heavy, balanced and release-heavy bursts; most releases name a live slot
  task automatic random_phase(int gap_pct, int stall_pct, int words);
    op_t               op;
    size_class_t       cls;
    logic [SLOT_W-1:0] slot;
    int                alloc_pct;
    int                start;
    req_gap_pct   = gap_pct;
    rsp_stall_pct = stall_pct;
    alloc_pct     = 50;
    for (int n = 0; n < words; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0:       alloc_pct = 85;
          1:       alloc_pct = 50;
          default: alloc_pct = 20;
        endcase
      end
      slot = SLOT_W'($urandom);
      if ($urandom_range(99) < alloc_pct) begin
        op  = OP_ALLOC;
        cls = ($urandom_range(9) == 0) ? CLASS_INVALID : size_class_t'($urandom_range(2));
      end else begin
        op  = OP_RELEASE;
        cls = size_class_t'($urandom_range(3));
        if ($urandom_range(4) != 0) begin
          start = $urandom_range(MAP_DEPTH - 1);
          for (int k = MAP_DEPTH - 1; k >= 0; k--) begin
            if (pool_map[(start + k) % MAP_DEPTH]) slot = SLOT_W'((start + k) % MAP_DEPTH);
          end
        end
      end
      send_request(op, cls, slot, 1'b0, '0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_request(REQUEST_TABLE[r].op, REQUEST_TABLE[r].size_class, REQUEST_TABLE[r].slot,
                   REQUEST_TABLE[r].typed, REQUEST_TABLE[r].want);
    end

    // Long hold-off while words keep coming fills the pipe and stalls the input.
    hold_off_requests++;
    random_phase(0, 0, PHASE_WORDS);
    random_phase(63, 0, PHASE_WORDS);
    random_phase(0, 63, PHASE_WORDS);
    hold_off_requests++;
    random_phase(28, 28, PHASE_WORDS);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
